// File: rtl/byte_window_class_stats_macros.svh
// Assertion macros for the checker file.
// Both sample on clk_i and are disabled while rst_ni is low.
`ifndef BYTE_WINDOW_CLASS_STATS_MACROS_SVH
`define BYTE_WINDOW_CLASS_STATS_MACROS_SVH

// Same-cycle implication.
`define BWCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bwcs assertion failed");

// Next-cycle implication.
`define BWCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bwcs assertion failed");

`endif

// File: rtl/bwcs_pkg.sv
`default_nettype none
package bwcs_pkg;

  // Fixed field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 7;
  localparam int unsigned PctW   = 7;

  // Default window limit
  localparam int unsigned MaxWindowDef = 64;

  // Shares are percent values
  localparam int unsigned PctScale = 100;

  // Threshold reset values
  localparam logic [PctW-1:0] PrintableMaxRst = 7'd10;
  localparam logic [PctW-1:0] ZeroMaxRst      = 7'd8;
  localparam logic [PctW-1:0] HighBitMinRst   = 7'd45;
  localparam logic [PctW-1:0] LeadMaxRst      = 7'd18;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CfgPrintableMax = 2'd0,
    CfgZeroMax      = 2'd1,
    CfgHighBitMin   = 2'd2,
    CfgLeadMax      = 2'd3
  } cfg_idx_e;

  // Class hits of one byte
  typedef struct packed {
    logic printable;
    logic high_bit;
    logic zero;
    logic lead;
  } byte_class_t;

  // Threshold set
  typedef struct packed {
    logic [PctW-1:0] printable_max;
    logic [PctW-1:0] zero_max;
    logic [PctW-1:0] high_bit_min;
    logic [PctW-1:0] lead_max;
  } thresh_t;

endpackage
`default_nettype wire

// File: rtl/byte_window_class_stats.sv
// Byte window class statistics. Takes one byte per clock unless stalled, a rate
// set by the single counter update stage, and counts it as printable (32..126,
// tab, CR, LF), high-bit, zero and x86 opcode lead; the byte flagged last closes
// the window and produces one result with all counts, the compressed-like verdict
// and the overflow flag, after which the counters clear. The last byte passes the
// input register, then the result register. Counts saturate at MAX_WINDOW; bytes
// beyond it only set window_overflow. Count outputs carry the low 7 bits.
// Thresholds are written over the cfg port (ready is always high); the user must
// write them only while the block is idle, which the block does not enforce.
`default_nettype none
module byte_window_class_stats #(
  parameter int unsigned MAX_WINDOW = bwcs_pkg::MaxWindowDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Byte input
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [bwcs_pkg::ByteW-1:0]    in_data_byte_i,
  input  wire logic                          in_last_byte_i,
  // Result output
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [bwcs_pkg::CountW-1:0]        out_window_length_o,
  output logic [bwcs_pkg::CountW-1:0]        out_printable_count_o,
  output logic [bwcs_pkg::CountW-1:0]        out_high_bit_count_o,
  output logic [bwcs_pkg::CountW-1:0]        out_zero_count_o,
  output logic [bwcs_pkg::CountW-1:0]        out_opcode_lead_count_o,
  output logic                               out_compressed_like_o,
  output logic                               out_window_overflow_o,
  // Threshold writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [bwcs_pkg::PctW-1:0]     cfg_data_i
);

  localparam int unsigned CntW = $clog2(MAX_WINDOW + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_WINDOW);
  localparam logic [CntW-1:0] One    = CntW'(1);

  // Threshold registers
  bwcs_pkg::thresh_t thresh_q, thresh_d;

  // Input register
  logic                       s1_valid_q, s1_valid_d;
  logic [bwcs_pkg::ByteW-1:0] s1_byte_q;
  logic                       s1_last_q;

  // Window counters
  logic [CntW-1:0] len_q, len_d, len_n;
  logic [CntW-1:0] pr_q, pr_d, pr_n;
  logic [CntW-1:0] hb_q, hb_d, hb_n;
  logic [CntW-1:0] ze_q, ze_d, ze_n;
  logic [CntW-1:0] ld_q, ld_d, ld_n;
  logic            ovf_q, ovf_d, ovf_n;

  // Result register
  logic                        res_valid_q, res_valid_d;
  logic [bwcs_pkg::CountW-1:0] res_len_q, res_pr_q, res_hb_q, res_ze_q, res_ld_q;
  logic                        res_comp_q, res_ovf_q;

  logic                  out_free, s1_fire, in_fire, res_load, full, comp;
  bwcs_pkg::byte_class_t cls;

  // Handshake
  assign out_free    = !res_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && (!s1_last_q || out_free);
  assign in_stall_o  = s1_valid_q && !s1_fire;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign res_load    = s1_fire && s1_last_q;
  assign cfg_ready_o = 1'b1;

  // Config decode
  always_comb begin
    thresh_d = thresh_q;
    if (cfg_valid_i) begin
      unique case (bwcs_pkg::cfg_idx_e'(cfg_index_i))
        bwcs_pkg::CfgPrintableMax: thresh_d.printable_max = cfg_data_i;
        bwcs_pkg::CfgZeroMax:      thresh_d.zero_max      = cfg_data_i;
        bwcs_pkg::CfgHighBitMin:   thresh_d.high_bit_min  = cfg_data_i;
        bwcs_pkg::CfgLeadMax:      thresh_d.lead_max      = cfg_data_i;
        default:                   thresh_d               = thresh_q;
      endcase
    end
  end

  bwcs_classify u_classify (
    .data_i  (s1_byte_q),
    .class_o (cls)
  );

  // Counts including the byte in the input register
  always_comb begin
    full  = (len_q == MaxCnt);
    len_n = len_q;
    pr_n  = pr_q;
    hb_n  = hb_q;
    ze_n  = ze_q;
    ld_n  = ld_q;
    ovf_n = ovf_q | full;
    if (!full) begin
      len_n = len_q + One;
      pr_n  = pr_q + (cls.printable ? One : '0);
      hb_n  = hb_q + (cls.high_bit  ? One : '0);
      ze_n  = ze_q + (cls.zero      ? One : '0);
      ld_n  = ld_q + (cls.lead      ? One : '0);
    end
  end

  bwcs_verdict #(
    .CntW (CntW)
  ) u_verdict (
    .len_i        (len_n),
    .printable_i  (pr_n),
    .high_bit_i   (hb_n),
    .zero_i       (ze_n),
    .lead_i       (ld_n),
    .thresh_i     (thresh_q),
    .compressed_o (comp)
  );

  // Counter update; the last byte clears the window
  always_comb begin
    len_d = len_q;
    pr_d  = pr_q;
    hb_d  = hb_q;
    ze_d  = ze_q;
    ld_d  = ld_q;
    ovf_d = ovf_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        len_d = '0;
        pr_d  = '0;
        hb_d  = '0;
        ze_d  = '0;
        ld_d  = '0;
        ovf_d = 1'b0;
      end else begin
        len_d = len_n;
        pr_d  = pr_n;
        hb_d  = hb_n;
        ze_d  = ze_n;
        ld_d  = ld_n;
        ovf_d = ovf_n;
      end
    end
  end

  // Valid bits
  always_comb begin
    s1_valid_d  = in_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_q);
    res_valid_d = res_load || (res_valid_q && out_stall_i);
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q.printable_max <= bwcs_pkg::PrintableMaxRst;
      thresh_q.zero_max      <= bwcs_pkg::ZeroMaxRst;
      thresh_q.high_bit_min  <= bwcs_pkg::HighBitMinRst;
      thresh_q.lead_max      <= bwcs_pkg::LeadMaxRst;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      len_q       <= '0;
      pr_q        <= '0;
      hb_q        <= '0;
      ze_q        <= '0;
      ld_q        <= '0;
      ovf_q       <= 1'b0;
    end else begin
      thresh_q    <= thresh_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      len_q       <= len_d;
      pr_q        <= pr_d;
      hb_q        <= hb_d;
      ze_q        <= ze_d;
      ld_q        <= ld_d;
      ovf_q       <= ovf_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= in_data_byte_i;
      s1_last_q <= in_last_byte_i;
    end
    if (res_load) begin
      res_len_q  <= bwcs_pkg::CountW'(len_n);
      res_pr_q   <= bwcs_pkg::CountW'(pr_n);
      res_hb_q   <= bwcs_pkg::CountW'(hb_n);
      res_ze_q   <= bwcs_pkg::CountW'(ze_n);
      res_ld_q   <= bwcs_pkg::CountW'(ld_n);
      res_comp_q <= comp;
      res_ovf_q  <= ovf_n;
    end
  end

  assign out_valid_o             = res_valid_q;
  assign out_window_length_o     = res_len_q;
  assign out_printable_count_o   = res_pr_q;
  assign out_high_bit_count_o    = res_hb_q;
  assign out_zero_count_o        = res_ze_q;
  assign out_opcode_lead_count_o = res_ld_q;
  assign out_compressed_like_o   = res_comp_q;
  assign out_window_overflow_o   = res_ovf_q;

endmodule
`default_nettype wire

// File: rtl/bwcs_classify.sv
`default_nettype none
module bwcs_classify (
  input  wire logic [bwcs_pkg::ByteW-1:0] data_i,
  output bwcs_pkg::byte_class_t           class_o
);

  localparam logic [bwcs_pkg::ByteW-1:0] PrintLo = 8'd32;
  localparam logic [bwcs_pkg::ByteW-1:0] PrintHi = 8'd126;
  localparam logic [bwcs_pkg::ByteW-1:0] Tab     = 8'd9;
  localparam logic [bwcs_pkg::ByteW-1:0] Lf      = 8'd10;
  localparam logic [bwcs_pkg::ByteW-1:0] Cr      = 8'd13;

  // x86 opcode lead set
  function automatic logic is_lead(input logic [bwcs_pkg::ByteW-1:0] b);
    logic hit;
    case (b) inside
      8'hE8, 8'hE9, 8'hEB, 8'h55, 8'h48, 8'h4C, 8'h60, 8'h90, 8'hFC,
      8'h68, 8'h58, 8'h65, 8'h8B, 8'h8D, 8'h89, 8'h83, 8'h31, 8'h33: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  always_comb begin
    class_o.printable = ((data_i >= PrintLo) && (data_i <= PrintHi)) ||
                        (data_i == Tab) || (data_i == Lf) || (data_i == Cr);
    class_o.high_bit  = data_i[bwcs_pkg::ByteW-1];
    class_o.zero      = (data_i == '0);
    class_o.lead      = is_lead(data_i);
  end

endmodule
`default_nettype wire

// File: rtl/bwcs_verdict.sv
`default_nettype none
module bwcs_verdict #(
  parameter int unsigned CntW = 7
) (
  input  wire logic [CntW-1:0]  len_i,
  input  wire logic [CntW-1:0]  printable_i,
  input  wire logic [CntW-1:0]  high_bit_i,
  input  wire logic [CntW-1:0]  zero_i,
  input  wire logic [CntW-1:0]  lead_i,
  input  wire bwcs_pkg::thresh_t thresh_i,
  output logic                  compressed_o
);

  localparam int unsigned ProdW = CntW + bwcs_pkg::PctW;
  localparam logic [ProdW-1:0] Scale = ProdW'(bwcs_pkg::PctScale);

  logic [ProdW-1:0] len_w;
  logic [ProdW-1:0] pr_lhs, ze_lhs, hb_lhs, ld_lhs;
  logic [ProdW-1:0] pr_rhs, ze_rhs, hb_rhs, ld_rhs;

  // Cross-multiplied shares: count * 100 against pct * length
  always_comb begin
    len_w  = ProdW'(len_i);
    pr_lhs = ProdW'(printable_i) * Scale;
    ze_lhs = ProdW'(zero_i) * Scale;
    hb_lhs = ProdW'(high_bit_i) * Scale;
    ld_lhs = ProdW'(lead_i) * Scale;
    pr_rhs = ProdW'(thresh_i.printable_max) * len_w;
    ze_rhs = ProdW'(thresh_i.zero_max) * len_w;
    hb_rhs = ProdW'(thresh_i.high_bit_min) * len_w;
    ld_rhs = ProdW'(thresh_i.lead_max) * len_w;
    compressed_o = (pr_lhs < pr_rhs) && (ze_lhs < ze_rhs) &&
                   (hb_lhs > hb_rhs) && (ld_lhs < ld_rhs);
  end

endmodule
`default_nettype wire

// File: rtl/bwcs_checker.sv
`default_nettype none
`include "byte_window_class_stats_macros.svh"
module bwcs_checker #(
  parameter int unsigned MAX_WINDOW = bwcs_pkg::MaxWindowDef
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic [bwcs_pkg::CountW-1:0] out_window_length_o,
  input wire logic [bwcs_pkg::CountW-1:0] out_printable_count_o,
  input wire logic [bwcs_pkg::CountW-1:0] out_high_bit_count_o,
  input wire logic [bwcs_pkg::CountW-1:0] out_zero_count_o,
  input wire logic [bwcs_pkg::CountW-1:0] out_opcode_lead_count_o,
  input wire logic                       out_compressed_like_o,
  input wire logic                       out_window_overflow_o
);

  // Counts are exact (not wrapped) only while the window fits in the port width
  localparam logic Exact = (MAX_WINDOW < (1 << bwcs_pkg::CountW));
  localparam logic [bwcs_pkg::CountW-1:0] MaxCnt = bwcs_pkg::CountW'(MAX_WINDOW);

  // A stalled result stays offered
  `BWCS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // Input only stalls behind a waiting result
  `BWCS_ASSERT_NOW(a_in_stall_cause, in_stall_o, out_valid_o && out_stall_i)

  // An overflowed window reports a full length
  `BWCS_ASSERT_NOW(a_ovf_full, out_valid_o && out_window_overflow_o,
                   out_window_length_o == MaxCnt)

  // No class count exceeds the window length
  `BWCS_ASSERT_NOW(a_counts_le_len, out_valid_o && Exact,
                   (out_printable_count_o <= out_window_length_o) &&
                   (out_high_bit_count_o <= out_window_length_o) &&
                   (out_zero_count_o <= out_window_length_o) &&
                   (out_opcode_lead_count_o <= out_window_length_o))

  // Compressed-like needs at least one high-bit byte
  `BWCS_ASSERT_NOW(a_comp_high, out_valid_o && out_compressed_like_o && Exact,
                   out_high_bit_count_o != '0)

endmodule

bind byte_window_class_stats bwcs_checker #(.MAX_WINDOW(MAX_WINDOW)) u_bwcs_checker (.*);
`default_nettype wire

// File: bench/tb_byte_window_class_stats.sv
module tb_byte_window_class_stats;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned WIN_LIMIT    = bwcs_pkg::MaxWindowDef;

  // x86 opcode lead bytes counted by the block
  localparam logic [bwcs_pkg::ByteW-1:0] OPCODE_LEADS [18] = '{
    8'hE8, 8'hE9, 8'hEB, 8'h55, 8'h48, 8'h4C, 8'h60, 8'h90, 8'hFC,
    8'h68, 8'h58, 8'h65, 8'h8B, 8'h8D, 8'h89, 8'h83, 8'h31, 8'h33
  };
  localparam logic [bwcs_pkg::ByteW-1:0] WHITESPACE [3] = '{8'd9, 8'd10, 8'd13};
  // Class edges, whitespace, leads and the byte extremes, one per window
  localparam logic [bwcs_pkg::ByteW-1:0] EDGE_BYTES [15] = '{
    8'h00, 8'hFF, 8'h7E, 8'h7F, 8'h20, 8'h1F, 8'h09, 8'h0A, 8'h0D,
    8'h08, 8'h0E, 8'hE8, 8'h33, 8'h80, 8'h90
  };

  // Byte mix of a random window
  typedef enum int unsigned {
    MixUniform = 0,
    MixHighBit = 1,
    MixText    = 2,
    MixCode    = 3
  } byte_mix_e;

  typedef struct {
    logic [bwcs_pkg::ByteW-1:0] data;
    logic                       last;
  } byte_item_t;

  typedef struct {
    logic [bwcs_pkg::CountW-1:0] length;
    logic [bwcs_pkg::CountW-1:0] printable;
    logic [bwcs_pkg::CountW-1:0] high_bit;
    logic [bwcs_pkg::CountW-1:0] zero;
    logic [bwcs_pkg::CountW-1:0] lead;
    logic                        compressed;
    logic                        overflow;
  } window_stats_t;

  // DUT signals
  logic                        clk_i;
  logic                        rst_ni = 1'b0;
  logic                        in_valid_i = 1'b0;
  logic                        in_stall_o;
  logic [bwcs_pkg::ByteW-1:0]  in_data_byte_i = '0;
  logic                        in_last_byte_i = 1'b0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [bwcs_pkg::CountW-1:0] out_window_length_o;
  logic [bwcs_pkg::CountW-1:0] out_printable_count_o;
  logic [bwcs_pkg::CountW-1:0] out_high_bit_count_o;
  logic [bwcs_pkg::CountW-1:0] out_zero_count_o;
  logic [bwcs_pkg::CountW-1:0] out_opcode_lead_count_o;
  logic                        out_compressed_like_o;
  logic                        out_window_overflow_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  logic [1:0]                  cfg_index_i = bwcs_pkg::CfgPrintableMax;
  logic [bwcs_pkg::PctW-1:0]   cfg_data_i = '0;

  // Stimulus and scoreboard state
  byte_item_t    byte_queue[$];
  window_stats_t stats_expected[$];
  int unsigned   bytes_queued = 0;
  int unsigned   bytes_taken = 0;
  logic          byte_taken = 1'b0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_stall_pct = 0;
  logic          hold_start = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   quiet_cycles = 0;
  int unsigned   mismatches = 0;

  // Predicted counters and thresholds
  int unsigned               run_len = 0;
  int unsigned               run_printable = 0;
  int unsigned               run_high = 0;
  int unsigned               run_zero = 0;
  int unsigned               run_lead = 0;
  logic                      run_ovf = 1'b0;
  logic [bwcs_pkg::PctW-1:0] thr_printable = bwcs_pkg::PrintableMaxRst;
  logic [bwcs_pkg::PctW-1:0] thr_zero = bwcs_pkg::ZeroMaxRst;
  logic [bwcs_pkg::PctW-1:0] thr_high = bwcs_pkg::HighBitMinRst;
  logic [bwcs_pkg::PctW-1:0] thr_lead = bwcs_pkg::LeadMaxRst;

  byte_window_class_stats dut (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .in_data_byte_i         (in_data_byte_i),
    .in_last_byte_i         (in_last_byte_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .out_window_length_o    (out_window_length_o),
    .out_printable_count_o  (out_printable_count_o),
    .out_high_bit_count_o   (out_high_bit_count_o),
    .out_zero_count_o       (out_zero_count_o),
    .out_opcode_lead_count_o(out_opcode_lead_count_o),
    .out_compressed_like_o  (out_compressed_like_o),
    .out_window_overflow_o  (out_window_overflow_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  function automatic logic is_opcode_lead(input logic [bwcs_pkg::ByteW-1:0] b);
    foreach (OPCODE_LEADS[i]) begin
      if (OPCODE_LEADS[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Count one accepted byte; a marked byte closes the window
  task automatic count_byte(input logic [bwcs_pkg::ByteW-1:0] b, input logic last);
    window_stats_t s;
    if (run_len >= WIN_LIMIT) begin
      run_ovf = 1'b1;
    end else begin
      run_len++;
      if ((b >= 8'd32 && b <= 8'd126) || b == 8'd9 || b == 8'd10 || b == 8'd13) begin
        run_printable++;
      end
      if (b[7]) run_high++;
      if (b == '0) run_zero++;
      if (is_opcode_lead(b)) run_lead++;
    end
    if (last) begin
      s.length     = run_len[bwcs_pkg::CountW-1:0];
      s.printable  = run_printable[bwcs_pkg::CountW-1:0];
      s.high_bit   = run_high[bwcs_pkg::CountW-1:0];
      s.zero       = run_zero[bwcs_pkg::CountW-1:0];
      s.lead       = run_lead[bwcs_pkg::CountW-1:0];
      s.compressed = (run_printable * bwcs_pkg::PctScale < thr_printable * run_len) &&
                     (run_zero * bwcs_pkg::PctScale < thr_zero * run_len) &&
                     (run_high * bwcs_pkg::PctScale > thr_high * run_len) &&
                     (run_lead * bwcs_pkg::PctScale < thr_lead * run_len);
      s.overflow   = run_ovf;
      stats_expected = {stats_expected, s};
      run_len       = 0;
      run_printable = 0;
      run_high      = 0;
      run_zero      = 0;
      run_lead      = 0;
      run_ovf       = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  // Monitor: config and byte accepts feed the predictor, results are checked
  always @(posedge clk_i) begin : monitor
    window_stats_t want;
    logic          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        case (bwcs_pkg::cfg_idx_e'(cfg_index_i))
          bwcs_pkg::CfgPrintableMax: thr_printable = cfg_data_i;
          bwcs_pkg::CfgZeroMax:      thr_zero = cfg_data_i;
          bwcs_pkg::CfgHighBitMin:   thr_high = cfg_data_i;
          bwcs_pkg::CfgLeadMax:      thr_lead = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (stats_expected.size() == 0) begin
          mismatches++;
          $display("%0t: result with no window pending, length %0d", $time,
                   out_window_length_o);
        end else begin
          want = stats_expected.pop_front();
          check_field("window_length", want.length, out_window_length_o);
          check_field("printable_count", want.printable, out_printable_count_o);
          check_field("high_bit_count", want.high_bit, out_high_bit_count_o);
          check_field("zero_count", want.zero, out_zero_count_o);
          check_field("opcode_lead_count", want.lead, out_opcode_lead_count_o);
          check_field("compressed_like", want.compressed, out_compressed_like_o);
          check_field("window_overflow", want.overflow, out_window_overflow_o);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        bytes_taken++;
        byte_taken = 1'b1;
        count_byte(in_data_byte_i, in_last_byte_i);
      end
      // Watchdog on stalled progress
      if (moved) begin
        quiet_cycles = 0;
      end else if (bytes_taken != bytes_queued || stats_expected.size() != 0) begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("byte_window_class_stats: mismatch");
        $finish;
      end
    end
  end

  // Byte driver: holds a stalled item, otherwise offers the next or idles
  always @(negedge clk_i) begin : byte_driver
    byte_item_t nxt;
    logic       offer;
    if (!in_valid_i || byte_taken) begin
      offer = 1'b0;
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_queue.pop_front();
        offer = 1'b1;
        in_data_byte_i <= nxt.data;
        in_last_byte_i <= nxt.last;
      end
      in_valid_i <= offer;
    end
    byte_taken = 1'b0;
  end

  // Result stall: random, or a long hold when requested
  always @(negedge clk_i) begin : stall_driver
    if (hold_start) begin
      hold_left = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [bwcs_pkg::ByteW-1:0] b, input logic last);
    byte_item_t it;
    it.data = b;
    it.last = last;
    byte_queue = {byte_queue, it};
    bytes_queued++;
  endtask

  function automatic logic [bwcs_pkg::ByteW-1:0] pick_byte(input byte_mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MixHighBit: if (roll < 80) return 8'($urandom_range(255, 128));
      MixText: begin
        if (roll < 75) return 8'($urandom_range(126, 32));
        if (roll < 85) return WHITESPACE[$urandom_range(2)];
      end
      MixCode: begin
        if (roll < 40) return OPCODE_LEADS[$urandom_range(17)];
        if (roll < 60) return 8'h00;
      end
      default: ;
    endcase
    return 8'($urandom);
  endfunction

  task automatic queue_window(input int unsigned len, input byte_mix_e mix);
    for (int unsigned i = 0; i < len; i++) begin
      push_byte(pick_byte(mix), i == len - 1);
    end
  endtask

  // Random windows, mostly short, some near or past the window limit
  task automatic stream_random(input int unsigned n_items, input bit short_only);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if (short_only) len = $urandom_range(3, 1);
      else if ($urandom_range(19) == 0) len = $urandom_range(72, 60);
      else len = $urandom_range(16, 1);
      queue_window(len, byte_mix_e'($urandom_range(3)));
      sent += len;
    end
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || stats_expected.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_threshold(input bwcs_pkg::cfg_idx_e idx,
                                 input logic [bwcs_pkg::PctW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_thresholds(input logic [bwcs_pkg::PctW-1:0] p,
                                 input logic [bwcs_pkg::PctW-1:0] z,
                                 input logic [bwcs_pkg::PctW-1:0] h,
                                 input logic [bwcs_pkg::PctW-1:0] l);
    write_threshold(bwcs_pkg::CfgPrintableMax, p);
    write_threshold(bwcs_pkg::CfgZeroMax, z);
    write_threshold(bwcs_pkg::CfgHighBitMin, h);
    write_threshold(bwcs_pkg::CfgLeadMax, l);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // Phases of stimulus; thresholds change only when the block is drained
  initial begin
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset thresholds, no idling: single-byte edge windows, then longer windows, some full
    set_idling(0, 0);
    foreach (EDGE_BYTES[i]) push_byte(EDGE_BYTES[i], 1'b1);
    push_byte(8'hE9, 1'b0);
    push_byte(8'h00, 1'b1);
    queue_window(WIN_LIMIT, MixHighBit);
    queue_window(WIN_LIMIT + 2, MixUniform);
    stream_random(250, 1'b0);
    wait_drained();

    // Loose limits, sender idling
    load_thresholds(7'd100, 7'd100, 7'd0, 7'd100);
    set_idling(84, 0);
    stream_random(250, 1'b0);
    wait_drained();

    // All thresholds zero, receiver stalling
    load_thresholds(7'd0, 7'd0, 7'd0, 7'd0);
    set_idling(0, 84);
    stream_random(250, 1'b0);
    wait_drained();

    // Random thresholds, both sides idling
    load_thresholds(7'($urandom_range(100)), 7'($urandom_range(100)),
                    7'($urandom_range(100)), 7'($urandom_range(100)));
    set_idling(35, 35);
    stream_random(250, 1'b0);
    wait_drained();

    // Printable, zero and lead thresholds above 100 percent; long result hold fills the block
    load_thresholds(7'd127, 7'd127, 7'd5, 7'd127);
    set_idling(0, 0);
    hold_start = 1'b1;
    stream_random(150, 1'b1);
    wait_drained();

    // Random thresholds, no idling
    load_thresholds(7'($urandom_range(100)), 7'($urandom_range(100)),
                    7'($urandom_range(100)), 7'($urandom_range(100)));
    stream_random(250, 1'b0);
    wait_drained();

    if (mismatches == 0) begin
      $display("byte_window_class_stats: match");
    end else begin
      $display("byte_window_class_stats: mismatch");
    end
    $finish;
  end

endmodule
